### hw/rtl/ocbc_pkg.sv
// shared types and constants of the overcurrent monitor with blink code
package ocbc_pkg;

   localparam int unsigned NUM_CUR = 7;             // current channels 4..10
   localparam logic [4:0]  CH_IGN = 5'd7;           // ignition
   localparam logic [4:0]  CH_VOLT = 5'd8;          // first slow channel
   localparam logic [3:0]  SEQ_SLOT_LAST = 4'd14;   // slow slot of a group
   localparam logic [3:0]  SEQ_GROUP_LAST = 4'd8;   // nine groups
   localparam logic [2:0]  FIRST_COUNT_CH = 3'd3;   // channels 3..6 count
   localparam logic [6:0]  CPA_RESET = 7'd50;
   localparam logic [7:0]  PAUSE_START = 8'd250;
   localparam logic [7:0]  PAUSE_SET = 8'd251;
   localparam logic [7:0]  PAUSE_END = 8'd255;
   localparam logic [3:0]  FIRST_SHOWN = 4'd4;

   localparam logic [3:0] TRIP_MULT [NUM_CUR] = '{4'd7, 4'd5, 4'd5, 4'd8, 4'd8, 4'd8, 4'd8};
   localparam logic [3:0] COUNT_MULT [NUM_CUR] = '{4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd2, 4'd2};

   // indicator status handed from the blink unit to the top level
   typedef struct packed {
      logic       led_on;
      logic [3:0] shown_channel;
   } blink_status_type;

   // one result word
   typedef struct packed {
      logic [4:0]  converted_channel;
      logic [4:0]  next_channel;
      logic [9:0]  sample_value;
      logic [15:0] current_word;
      logic        trip_event;
      logic [6:0]  tripped_mask;
      logic        led_on;
      logic [3:0]  shown_channel;
   } rsp_word_type;

endpackage

### hw/rtl/ocbc_blink.sv
// blink code generator for the tripped current channels
module ocbc_blink
   import ocbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             tick,
   input  logic [6:0]       trip_flags,
   output blink_status_type status_in
);

   logic       led_ff, led_in;
   logic [3:0] chan_ff, chan_in;
   logic [7:0] phase_ff, phase_in;

   // lowest tripped channel
   function automatic logic [3:0] first_tripped(input logic [6:0] flags);
      logic [3:0] ch;
      ch = '0;
      for (int i = NUM_CUR - 1; i >= 0; i--) begin
         if (flags[i]) begin
            ch = FIRST_SHOWN + 4'(i);
         end
      end
      return ch;
   endfunction

   // next tripped channel after cur, cyclically, cur itself last
   function automatic logic [3:0] next_tripped(input logic [3:0] cur,
                                               input logic [6:0] flags);
      logic [3:0] ch;
      logic [3:0] j;
      logic [2:0] idx;
      ch = '0;
      idx = 3'(cur - FIRST_SHOWN);
      for (int k = NUM_CUR; k >= 1; k--) begin
         j = 4'(idx) + 4'(k);
         if (j >= 4'(NUM_CUR)) begin
            j = j - 4'(NUM_CUR);
         end
         if (flags[j[2:0]]) begin
            ch = FIRST_SHOWN + j;
         end
      end
      return ch;
   endfunction

   always_comb begin
      logic [3:0] ch;
      logic [7:0] ph;
      logic       paused;
      ch = '0;
      ph = '0;
      paused = 1'b0;
      led_in = led_ff;
      chan_in = chan_ff;
      phase_in = phase_ff;
      if (tick) begin
         if (trip_flags == '0) begin
            led_in = 1'b1;
            chan_in = '0;
            phase_in = '0;
         end else if (led_ff) begin
            led_in = 1'b0;
         end else begin
            ch = (chan_ff == '0) ? first_tripped(trip_flags) : chan_ff;
            ph = phase_ff;
            chan_in = ch;
            if (ph > PAUSE_START) begin
               ph = ph + 8'd1;
               if (ph < PAUSE_END) begin
                  paused = 1'b1;
                  phase_in = ph;
               end else begin
                  ph = '0;
               end
            end
            if (!paused) begin
               led_in = 1'b1;
               if ({1'b0, ph} + 9'd1 < {5'd0, ch}) begin
                  phase_in = ph + 8'd1;
               end else begin
                  phase_in = PAUSE_SET;
                  if (ch >= FIRST_SHOWN && ch <= FIRST_SHOWN + 4'(NUM_CUR - 1)) begin
                     chan_in = next_tripped(ch, trip_flags);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff <= 1'b1;
         chan_ff <= '0;
         phase_ff <= '0;
      end else begin
         led_ff <= led_in;
         chan_ff <= chan_in;
         phase_ff <= phase_in;
      end
   end

   assign status_in.led_on = led_in;
   assign status_in.shown_channel = chan_in;

endmodule

### hw/rtl/overcurrent_monitor_blink_code_top.sv
// top level of the overcurrent monitor with blink code indicator
//
//  channel | ports                          | direction | handshake
//  --------+--------------------------------+-----------+-----------------------
//  req     | req_op, req_adc_result         | in        | req_valid / req_stall
//  rsp     | rsp_converted_channel .. shown | out       | rsp_valid / rsp_stall
//  csr     | csr_wr_data (counts_per_amp)   | in        | csr_wr_en, no wait
//
// one word accepted per cycle unless req_stall is high; its result is registered in the output or skid register
// the word memory is read ahead for the channel in conversion, so the one read port
// and one write port of the memory serve each word
// reset: synchronous, active high; sequence at its start, words and trip flags clear,
// led lit, counts_per_amp 50
// a stalled result moves into a skid register; req_stall rises only when both hold
module overcurrent_monitor_blink_code_top
   import ocbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [9:0]  req_adc_result,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_converted_channel,
   output logic [4:0]  rsp_next_channel,
   output logic [9:0]  rsp_sample_value,
   output logic [15:0] rsp_current_word,
   output logic        rsp_trip_event,
   output logic [6:0]  rsp_tripped_mask,
   output logic        rsp_led_on,
   output logic [3:0]  rsp_shown_channel,
   // configuration
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   // control and sequence state
   logic [6:0]  cpa_ff;
   logic [4:0]  conv_ff, conv_in;
   logic [3:0]  slot_ff, slot_in;
   logic [3:0]  group_ff, group_in;
   logic [6:0]  trip_ff, trip_in;

   // word memory with valid bits, read ahead into a register
   logic [15:0] word_mem [NUM_CUR];
   logic [NUM_CUR-1:0] word_valid_ff;
   logic [15:0] rd_q_ff;
   logic        rd_valid_ff;
   logic        fwd_ff;
   logic [15:0] fwd_data_ff;
   logic [2:0]  rd_addr;

   // output register and skid stage
   rsp_word_type rsp_ff, skid_ff, rsp_new;
   logic         rsp_valid_ff, skid_valid_ff;

   logic        accept, conv_acc, tick;
   logic        is_cur, count_ch, over_trip, over_cnt, wr_en, trip_hit;
   logic [2:0]  cur_sel;
   logic [4:0]  next_ch;
   logic [15:0] stored, word_new;
   logic [10:0] trip_lim, cnt_lim;
   logic [5:0]  cnt_new;
   logic        out_ready;
   blink_status_type blink_status;

   assign accept = req_valid && !req_stall;
   assign conv_acc = accept && !req_op;
   assign tick = accept && req_op;

   // sequence: seven current channels each followed by ignition, then one slow channel
   always_comb begin
      if (slot_ff == SEQ_SLOT_LAST) begin
         next_ch = CH_VOLT + {1'b0, group_ff};
      end else if (slot_ff[0]) begin
         next_ch = CH_IGN;
      end else begin
         next_ch = {2'b00, slot_ff[3:1]};
      end
   end

   always_comb begin
      slot_in = slot_ff;
      group_in = group_ff;
      conv_in = conv_ff;
      if (conv_acc) begin
         conv_in = next_ch;
         if (slot_ff == SEQ_SLOT_LAST) begin
            slot_in = '0;
            group_in = (group_ff == SEQ_GROUP_LAST) ? 4'd0 : group_ff + 4'd1;
         end else begin
            slot_in = slot_ff + 4'd1;
         end
      end
   end

   // sample handling for the channel in conversion
   assign is_cur = conv_ff < 5'(NUM_CUR);
   assign cur_sel = is_cur ? conv_ff[2:0] : 3'd0;
   assign count_ch = cur_sel >= FIRST_COUNT_CH;

   // entries never written read as zero; same-entry write forwarded
   assign stored = fwd_ff ? fwd_data_ff : (rd_valid_ff ? rd_q_ff : 16'd0);

   assign trip_lim = 11'(TRIP_MULT[cur_sel]) * 11'(cpa_ff);
   assign cnt_lim = 11'(COUNT_MULT[cur_sel]) * 11'(cpa_ff);
   assign over_trip = {1'b0, req_adc_result} > trip_lim;
   assign over_cnt = {1'b0, req_adc_result} > cnt_lim;

   // trip keeps the count, else count up (wrapping) or clear
   always_comb begin
      if (over_trip) begin
         cnt_new = stored[15:10];
      end else if (over_cnt) begin
         cnt_new = stored[15:10] + 6'd1;
      end else begin
         cnt_new = '0;
      end
      word_new = count_ch ? {cnt_new, req_adc_result} : {6'd0, req_adc_result};
   end

   assign wr_en = conv_acc && is_cur;
   assign trip_hit = wr_en && over_trip;
   assign trip_in = trip_ff | (trip_hit ? (7'd1 << cur_sel) : 7'd0);

   // prefetch address follows the next channel in conversion
   assign rd_addr = (conv_in < 5'(NUM_CUR)) ? conv_in[2:0] : 3'd0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem[cur_sel] <= word_new;
      end
      rd_q_ff <= word_mem[rd_addr];
      fwd_data_ff <= word_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
         rd_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            word_valid_ff[cur_sel] <= 1'b1;
         end
         rd_valid_ff <= word_valid_ff[rd_addr];
         fwd_ff <= wr_en && (cur_sel == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpa_ff <= CPA_RESET;
         conv_ff <= '0;
         slot_ff <= '0;
         group_ff <= '0;
         trip_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            cpa_ff <= csr_wr_data;
         end
         conv_ff <= conv_in;
         slot_ff <= slot_in;
         group_ff <= group_in;
         trip_ff <= trip_in;
      end
   end

   ocbc_blink u_blink (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .trip_flags (trip_ff),
      .status_in  (blink_status)
   );

   // result word; a tick echoes the channel in conversion, with zero sample and word
   always_comb begin
      rsp_new.converted_channel = conv_ff;
      rsp_new.next_channel = conv_in;
      rsp_new.sample_value = req_op ? 10'd0 : req_adc_result;
      rsp_new.current_word = wr_en ? word_new : 16'd0;
      rsp_new.trip_event = trip_hit;
      rsp_new.tripped_mask = trip_in;
      rsp_new.led_on = blink_status.led_on;
      rsp_new.shown_channel = blink_status.shown_channel;
   end

   // output register with skid stage
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_ff <= skid_valid_ff ? skid_ff : rsp_new;
      end else if (accept) begin
         skid_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_converted_channel = rsp_ff.converted_channel;
   assign rsp_next_channel = rsp_ff.next_channel;
   assign rsp_sample_value = rsp_ff.sample_value;
   assign rsp_current_word = rsp_ff.current_word;
   assign rsp_trip_event = rsp_ff.trip_event;
   assign rsp_tripped_mask = rsp_ff.tripped_mask;
   assign rsp_led_on = rsp_ff.led_on;
   assign rsp_shown_channel = rsp_ff.shown_channel;

endmodule

### hw/rtl/ocbc_checker.sv
// port-level checker of the overcurrent monitor, bound to the top level
module ocbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_converted_channel,
   input logic [4:0]  rsp_next_channel,
   input logic [9:0]  rsp_sample_value,
   input logic        rsp_trip_event,
   input logic [6:0]  rsp_tripped_mask,
   input logic        rsp_led_on,
   input logic [3:0]  rsp_shown_channel
);

   // with nothing tripped the led is steady on and no channel is shown
   a_steady_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tripped_mask == 7'd0 |-> rsp_led_on && rsp_shown_channel == 4'd0)
      else $error("led not steady on with no trip");

   // a trip always leaves a sticky flag
   a_trip_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trip_event |-> rsp_tripped_mask != 7'd0)
      else $error("trip event without trip flag");

   // shown channel is none or a current channel
   a_shown_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shown_channel != 4'd0 |-> rsp_shown_channel >= 4'd4 &&
      rsp_shown_channel <= 4'd10)
      else $error("shown channel out of range");

   // channel codes stay within the sequence
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_converted_channel <= 5'd16 && rsp_next_channel <= 5'd16)
      else $error("channel code out of range");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_value) &&
      $stable(rsp_converted_channel))
      else $error("stalled word changed");

endmodule

bind overcurrent_monitor_blink_code_top ocbc_checker u_ocbc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_converted_channel (rsp_converted_channel),
   .rsp_next_channel      (rsp_next_channel),
   .rsp_sample_value      (rsp_sample_value),
   .rsp_trip_event        (rsp_trip_event),
   .rsp_tripped_mask      (rsp_tripped_mask),
   .rsp_led_on            (rsp_led_on),
   .rsp_shown_channel     (rsp_shown_channel)
);

### verif/tb.sv
// self-checking testbench of the overcurrent monitor with blink code indicator
module tb;
   import ocbc_pkg::*;

   // word kinds on the request channel
   localparam logic OP_ADC = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // conversion sequence: nine groups of fifteen slots
   localparam int GROUP_LEN = int'(SEQ_SLOT_LAST) + 1;
   localparam int SEQ_STEPS = GROUP_LEN * (int'(SEQ_GROUP_LAST) + 1);
   localparam logic [9:0] ADC_MAX = 10'h3FF;

   // run control
   localparam int IDLE_STRETCH = 440;   // words per idling mode
   localparam int CYCLE_LIMIT = 100000;

   // tracks the block's state, predicts each result word and checks it on arrival
   class ocbc_tracker;
      logic [6:0]   cpa = CPA_RESET;
      logic [7:0]   seq_pos = '0;
      logic [4:0]   conv_ch = '0;
      logic [15:0]  cur_word [NUM_CUR] = '{default: '0};
      logic [6:0]   trips = '0;
      logic         lit = 1'b1;
      logic [3:0]   blink_ch = '0;
      logic [7:0]   phase = '0;
      rsp_word_type expected_words [$];
      int           mismatches = 0;

      function int trip_limit(int ch);
         return int'(TRIP_MULT[ch]) * int'(cpa);
      endfunction

      function int count_limit(int ch);
         return int'(COUNT_MULT[ch]) * int'(cpa);
      endfunction

      function logic [4:0] seq_at(logic [7:0] pos);
         int grp;
         int slot;
         grp = int'(pos) / GROUP_LEN;
         slot = int'(pos) % GROUP_LEN;
         if (slot == int'(SEQ_SLOT_LAST)) return 5'(int'(CH_VOLT) + grp);
         if (slot % 2 == 1) return CH_IGN;
         return 5'(slot / 2);
      endfunction

      // tripped channel after cur_ch, wrapping, cur_ch itself last
      function logic [3:0] next_shown(logic [3:0] cur_ch);
         int k;
         int idx;
         for (k = 1; k <= int'(NUM_CUR); k++) begin
            idx = (int'(cur_ch) - int'(FIRST_SHOWN) + k) % int'(NUM_CUR);
            if (trips[idx]) return 4'(int'(FIRST_SHOWN) + idx);
         end
         return '0;
      endfunction

      function void led_step();
         bit resume;
         if (trips == '0) begin
            lit = 1'b1;
            blink_ch = '0;
            phase = '0;
         end else if (lit) begin
            lit = 1'b0;
         end else begin
            if (blink_ch == '0)
               blink_ch = next_shown(4'(int'(FIRST_SHOWN) + int'(NUM_CUR) - 1));
            resume = 1'b1;
            if (phase > PAUSE_START) begin
               phase = phase + 8'd1;
               if (phase < PAUSE_END) resume = 1'b0;
               else phase = '0;
            end
            if (resume) begin
               lit = 1'b1;
               if (int'(phase) + 1 < int'(blink_ch)) begin
                  phase = phase + 8'd1;
               end else begin
                  phase = PAUSE_SET;
                  blink_ch = next_shown(blink_ch);
               end
            end
         end
      endfunction

      // accepted request word: update state and queue the expected result
      function void take_word(logic op, logic [9:0] adc);
         rsp_word_type w;
         logic [5:0]   cnt;
         logic [2:0]   idx;
         w = '0;
         w.converted_channel = conv_ch;
         w.next_channel = conv_ch;
         if (op == OP_ADC) begin
            w.sample_value = adc;
            if (int'(conv_ch) < int'(NUM_CUR)) begin
               idx = conv_ch[2:0];
               cnt = cur_word[idx][15:10];
               if (int'(adc) > trip_limit(int'(idx))) begin
                  w.trip_event = 1'b1;
                  trips[idx] = 1'b1;
               end else if (idx >= FIRST_COUNT_CH) begin
                  if (int'(adc) > count_limit(int'(idx))) cnt = cnt + 6'd1;
                  else cnt = '0;
               end
               cur_word[idx] = {cnt, adc};
               w.current_word = cur_word[idx];
            end
            conv_ch = seq_at(seq_pos);
            w.next_channel = conv_ch;
            seq_pos = (int'(seq_pos) == SEQ_STEPS - 1) ? '0 : seq_pos + 8'd1;
         end else begin
            led_step();
         end
         w.tripped_mask = trips;
         w.led_on = lit;
         w.shown_channel = blink_ch;
         expected_words.push_back(w);
      endfunction

      function void match(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
         end
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         match("converted_channel", 16'(want.converted_channel),
               16'(got.converted_channel));
         match("next_channel", 16'(want.next_channel), 16'(got.next_channel));
         match("sample_value", 16'(want.sample_value), 16'(got.sample_value));
         match("current_word", want.current_word, got.current_word);
         match("trip_event", 16'(want.trip_event), 16'(got.trip_event));
         match("tripped_mask", 16'(want.tripped_mask), 16'(got.tripped_mask));
         match("led_on", 16'(want.led_on), 16'(got.led_on));
         match("shown_channel", 16'(want.shown_channel), 16'(got.shown_channel));
      endfunction

      function int waiting();
         return expected_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_ADC;
   logic [9:0]  req_adc_result = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_converted_channel;
   logic [4:0]  rsp_next_channel;
   logic [9:0]  rsp_sample_value;
   logic [15:0] rsp_current_word;
   logic        rsp_trip_event;
   logic [6:0]  rsp_tripped_mask;
   logic        rsp_led_on;
   logic [3:0]  rsp_shown_channel;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   rsp_word_type seen_word;
   ocbc_tracker  book = new();
   int           sent = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           cycles = 0;

   overcurrent_monitor_blink_code_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_adc_result        (req_adc_result),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_converted_channel (rsp_converted_channel),
      .rsp_next_channel      (rsp_next_channel),
      .rsp_sample_value      (rsp_sample_value),
      .rsp_current_word      (rsp_current_word),
      .rsp_trip_event        (rsp_trip_event),
      .rsp_tripped_mask      (rsp_tripped_mask),
      .rsp_led_on            (rsp_led_on),
      .rsp_shown_channel     (rsp_shown_channel),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   // result ports gathered in struct order
   assign seen_word = {rsp_converted_channel, rsp_next_channel, rsp_sample_value,
                       rsp_current_word, rsp_trip_event, rsp_tripped_mask,
                       rsp_led_on, rsp_shown_channel};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog: a hang or a lost result ends the run as a failure
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: check the word taken at this edge, then pick the stall for the next one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_result(seen_word);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // present one word and hold it until it is taken; returns in the step of acceptance
   // so the caller either presents the next word or lowers valid in that step
   task automatic drive_word(logic op, logic [9:0] adc);
      // idling mode moves on every stretch of words: slow receiver, slow sender, neither
      case (sent / IDLE_STRETCH)
         0: begin
            send_idle_pct = 14;
            recv_idle_pct = 47;
         end
         1: begin
            send_idle_pct = 47;
            recv_idle_pct = 14;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_adc_result <= adc;
      do @(posedge clock); while (req_stall);
      book.take_word(op, adc);
      sent++;
   endtask

   // sender holds off until every expected word is back, then a short margin
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.waiting() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cpa(logic [6:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      book.cpa = value;
      csr_wr_en <= 1'b0;
   endtask

   // sample aimed at the limits of the channel now in conversion
   function automatic logic [9:0] pick_sample(int trip_pct, bit push_count);
      int ch;
      int tl;
      int cl;
      ch = int'(book.conv_ch);
      if (ch >= int'(NUM_CUR)) begin
         case ($urandom_range(9))
            0: return '0;
            1: return ADC_MAX;
            default: return 10'($urandom_range(ADC_MAX));
         endcase
      end
      tl = book.trip_limit(ch);
      cl = book.count_limit(ch);
      if ($urandom_range(99) < trip_pct) return 10'($urandom_range(ADC_MAX, tl + 1));
      if (tl == 0) return '0;
      // keep the first counting channel above its count limit so its count wraps
      if (push_count && ch == int'(FIRST_COUNT_CH) && cl < tl)
         return 10'($urandom_range(tl, cl + 1));
      case ($urandom_range(5))
         0: return '0;
         1: return 10'(tl);
         2: return 10'(cl);
         3: return 10'((cl < tl) ? cl + 1 : tl);
         4: return 10'($urandom_range(cl, 0));
         default: return 10'($urandom_range(tl, 0));
      endcase
   endfunction

   task automatic run_random(int count, int tick_pct, int trip_pct, bit push_count);
      repeat (count) begin
         if ($urandom_range(99) < tick_pct)
            drive_word(OP_TICK, 10'($urandom_range(ADC_MAX)));
         else
            drive_word(OP_ADC, pick_sample(trip_pct, push_count));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // top limit: the counting channels trip only above 1016, so counting is seen on its own
      write_cpa(7'd127);
      // walk the first group of the sequence by hand
      drive_word(OP_TICK, 10'd0);      // nothing tripped, led steady
      drive_word(OP_ADC, 10'd0);       // ch 4, smallest sample
      drive_word(OP_ADC, 10'd889);     // ch 4 again, right at its trip limit
      drive_word(OP_ADC, ADC_MAX);     // ignition, largest sample just echoed
      drive_word(OP_ADC, 10'd635);     // ch 5 at its trip limit
      drive_word(OP_TICK, ADC_MAX);    // tick ignores the sample
      drive_word(OP_ADC, 10'd0);       // ignition
      drive_word(OP_ADC, 10'd1);       // ch 6
      drive_word(OP_ADC, 10'd682);     // ignition, alternating bits
      drive_word(OP_ADC, 10'd381);     // ch 7 at its count limit, count cleared
      drive_word(OP_ADC, 10'd341);     // ignition, other alternating bits
      drive_word(OP_ADC, 10'd382);     // ch 8 just above its count limit
      drive_word(OP_ADC, 10'd5);       // ignition
      drive_word(OP_ADC, 10'd1016);    // ch 9 at its trip limit, counts
      drive_word(OP_ADC, 10'd512);     // ignition
      drive_word(OP_ADC, 10'd255);     // ch 10 just above its count limit
      drive_word(OP_ADC, 10'd0);       // ignition, voltage next
      drive_word(OP_ADC, ADC_MAX);     // voltage
      // long run of conversions: the first counting channel wraps its count
      run_random(1000, 1, 0, 1'b1);
      settle();

      // reset-value limits, mostly ticks: few channels trip, blink code with one or two
      write_cpa(CPA_RESET);
      run_random(120, 60, 8, 1'b0);
      settle();

      // zero scale: every nonzero current sample trips
      write_cpa(7'd0);
      run_random(60, 30, 50, 1'b0);
      settle();

      // smallest nonzero scale, tick heavy so the blink code goes round the tripped set
      write_cpa(7'd1);
      run_random(130, 75, 30, 1'b0);
      settle();

      if (book.mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
